// ----- sv/cpbf_pkg.sv -----
// ---------------------------------------------------------------------------
// cpbf_pkg - shared definitions for the closest pair search block
// Sizes, payload types and the command/status groups between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package cpbf_pkg;

    // Point store capacity and stored coordinate width
    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;

    // Port field width (fixed by the transaction format)
    localparam int FIELD_BITS = 16;

    localparam int IDX_BITS  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_POINTS + 1);
    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int DIST_BITS = 2 * COORD_BITS + 2;

    typedef logic signed [FIELD_BITS-1:0] t_field;
    typedef logic [COORD_BITS-1:0]        t_coord;
    typedef logic [2*COORD_BITS-1:0]      t_entry;
    typedef logic [IDX_BITS-1:0]          t_idx;
    typedef logic [CNT_BITS-1:0]          t_cnt;
    typedef logic [SQ_BITS-1:0]           t_sq;
    typedef logic [DIST_BITS-1:0]         t_dist;

    // Controller to datapath
    typedef struct packed {
        logic load;        // point transaction accepted
        logic pair_vld;    // a pair (addr_a, addr_b) enters the distance pipe
        logic rd_en;       // read the store at both ports
        logic rd_best;     // read addresses come from the best pair
        logic out_second;  // result payload shows the second point
        logic clear_set;   // set finished: clear count, flag and best
        t_idx addr_a;
        t_idx addr_b;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_cnt point_count;
        logic pipe_busy;
    } t_status;

endpackage

// ----- sv/cpbf_point_if.sv -----
// ---------------------------------------------------------------------------
// cpbf_point_if - input point channel
// Valid/ready channel carrying one point and its end-of-set mark.
// ---------------------------------------------------------------------------
interface cpbf_point_if import cpbf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field point_x;
    t_field point_y;
    logic   last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

// ----- sv/cpbf_result_if.sv -----
// ---------------------------------------------------------------------------
// cpbf_result_if - result point channel
// Valid/ready channel carrying one point of the closest pair.
// ---------------------------------------------------------------------------
interface cpbf_result_if import cpbf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field result_x;
    t_field result_y;
    logic   last_of_pair;
    logic   truncated;

    modport source (output valid, output result_x, output result_y,
                    output last_of_pair, output truncated, input ready);
    modport sink   (input valid, input result_x, input result_y,
                    input last_of_pair, input truncated, output ready);
endinterface

// ----- sv/cpbf_dp.sv -----
// ---------------------------------------------------------------------------
// cpbf_dp - datapath of the closest pair search
// Point store (one write, two registered reads), squared distance
// pipeline, running minimum and result payload.
// ---------------------------------------------------------------------------
module cpbf_dp import cpbf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_field  i_point_x,
    input  t_field  i_point_y,
    output t_status o_status,
    output t_field  o_result_x,
    output t_field  o_result_y,
    output logic    o_truncated
);

    t_entry r_store [MAX_POINTS];

    t_cnt   r_count;
    logic   r_overflow;
    t_dist  r_best;
    t_idx   r_best_i;
    t_idx   r_best_j;

    // stage 1: registered store reads
    logic   r_p1_vld;
    t_idx   r_p1_i, r_p1_j;
    t_entry r_rd_a, r_rd_b;
    // stage 2: absolute differences
    logic   r_p2_vld;
    t_idx   r_p2_i, r_p2_j;
    t_coord r_dx, r_dy;
    // stage 3: squares
    logic   r_p3_vld;
    t_idx   r_p3_i, r_p3_j;
    t_sq    r_sx, r_sy;

    logic   w_full;
    t_idx   w_addr_a, w_addr_b;
    logic signed [COORD_BITS:0] w_diff_x, w_diff_y;
    t_coord n_dx, n_dy;
    t_dist  w_sum;

    assign w_full   = (r_count == t_cnt'(MAX_POINTS));
    assign w_addr_a = i_cmd.rd_best ? r_best_i : i_cmd.addr_a;
    assign w_addr_b = i_cmd.rd_best ? r_best_j : i_cmd.addr_b;

    // point store write and dual read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            r_store[r_count[IDX_BITS-1:0]] <= {COORD_BITS'(i_point_x), COORD_BITS'(i_point_y)};
        end
        if (i_cmd.rd_en) begin
            r_rd_a <= r_store[w_addr_a];
            r_rd_b <= r_store[w_addr_b];
        end
    end

    // absolute coordinate differences, sign-extended by one bit
    always_comb begin
        w_diff_x = $signed({r_rd_a[SQ_BITS-1], r_rd_a[SQ_BITS-1:COORD_BITS]})
                 - $signed({r_rd_b[SQ_BITS-1], r_rd_b[SQ_BITS-1:COORD_BITS]});
        w_diff_y = $signed({r_rd_a[COORD_BITS-1], r_rd_a[COORD_BITS-1:0]})
                 - $signed({r_rd_b[COORD_BITS-1], r_rd_b[COORD_BITS-1:0]});
        n_dx = w_diff_x[COORD_BITS] ? COORD_BITS'(-w_diff_x) : w_diff_x[COORD_BITS-1:0];
        n_dy = w_diff_y[COORD_BITS] ? COORD_BITS'(-w_diff_y) : w_diff_y[COORD_BITS-1:0];
    end

    assign w_sum = t_dist'(r_sx) + t_dist'(r_sy);

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_p1_i <= i_cmd.addr_a;
        r_p1_j <= i_cmd.addr_b;
        r_p2_i <= r_p1_i;
        r_p2_j <= r_p1_j;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_p3_i <= r_p2_i;
        r_p3_j <= r_p2_j;
        r_sx   <= t_sq'(r_dx) * t_sq'(r_dx);
        r_sy   <= t_sq'(r_dy) * t_sq'(r_dy);
    end

    // control state: count, overflow flag, pipe valids, running minimum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_best     <= '1;
            r_best_i   <= '0;
            r_best_j   <= '0;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_p3_vld   <= 1'b0;
        end else begin
            r_p1_vld <= i_cmd.pair_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            if (i_cmd.clear_set) begin
                r_count    <= '0;
                r_overflow <= 1'b0;
                r_best     <= '1;
                r_best_i   <= '0;
                r_best_j   <= '0;
            end else begin
                if (i_cmd.load) begin
                    if (w_full) begin
                        r_overflow <= 1'b1;
                    end else begin
                        r_count <= r_count + t_cnt'(1);
                    end
                end
                // strict compare keeps the earliest pair on ties
                if (r_p3_vld && (w_sum < r_best)) begin
                    r_best   <= w_sum;
                    r_best_i <= r_p3_i;
                    r_best_j <= r_p3_j;
                end
            end
        end
    end

    assign o_status.point_count = r_count;
    assign o_status.pipe_busy   = r_p1_vld | r_p2_vld | r_p3_vld;

    // result payload, masked coordinates zero-extended to field width
    assign o_result_x  = i_cmd.out_second ? t_field'(r_rd_b[SQ_BITS-1:COORD_BITS])
                                          : t_field'(r_rd_a[SQ_BITS-1:COORD_BITS]);
    assign o_result_y  = i_cmd.out_second ? t_field'(r_rd_b[COORD_BITS-1:0])
                                          : t_field'(r_rd_a[COORD_BITS-1:0]);
    assign o_truncated = r_overflow;

endmodule

// ----- sv/cpbf_ctrl.sv -----
// ---------------------------------------------------------------------------
// cpbf_ctrl - controller of the closest pair search
// Sequences point loading, the i<j pair sweep, pipeline drain, the fetch
// of the best pair and the two result transactions.
// ---------------------------------------------------------------------------
module cpbf_ctrl import cpbf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_point,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_DRAIN,
        ST_FETCH,
        ST_OUT0,
        ST_OUT1
    } t_state;

    t_state r_state;
    t_cnt   r_i;
    t_cnt   r_j;

    logic   w_load;
    logic   w_has_pair;
    logic   w_row_end;
    logic   w_last_pair;

    assign w_load      = i_in_valid && (r_state == ST_LOAD);
    assign w_has_pair  = (i_status.point_count >= t_cnt'(2));
    assign w_row_end   = (r_j == i_status.point_count - t_cnt'(1));
    assign w_last_pair = w_row_end && (r_i == i_status.point_count - t_cnt'(2));

    // commands decoded from state
    always_comb begin
        o_in_ready       = (r_state == ST_LOAD);
        o_out_valid      = (r_state == ST_OUT0) || (r_state == ST_OUT1);
        o_cmd.load       = w_load;
        o_cmd.pair_vld   = (r_state == ST_SEARCH) && w_has_pair;
        o_cmd.rd_best    = (r_state == ST_FETCH);
        o_cmd.rd_en      = o_cmd.pair_vld || o_cmd.rd_best;
        o_cmd.out_second = (r_state == ST_OUT1);
        o_cmd.clear_set  = (r_state == ST_OUT1) && i_out_ready;
        o_cmd.addr_a     = r_i[IDX_BITS-1:0];
        o_cmd.addr_b     = r_j[IDX_BITS-1:0];
    end

    // state and pair counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    r_i <= '0;
                    r_j <= t_cnt'(1);
                    if (w_load && i_last_point) begin
                        r_state <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (!w_has_pair || w_last_pair) begin
                        r_state <= ST_DRAIN;
                    end else if (w_row_end) begin
                        r_i <= r_i + t_cnt'(1);
                        r_j <= r_i + t_cnt'(2);
                    end else begin
                        r_j <= r_j + t_cnt'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!i_status.pipe_busy) begin
                        r_state <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    r_state <= ST_OUT0;
                end
                ST_OUT0: begin
                    if (i_out_ready) begin
                        r_state <= ST_OUT1;
                    end
                end
                ST_OUT1: begin
                    if (i_out_ready) begin
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

// ----- sv/closest_pair_brute_force.sv -----
// Loading: a point transaction is accepted whenever the block is loading; after
//   the last point, all i<j pairs of the N held points are swept (one pair per
//   cycle through a four-stage read/difference/square/compare pipe), then the
//   pipe drains and the best pair is fetched, then the two result transactions.
// Sets: one set at a time through the single shared distance pipe.
// Reset: synchronous, active low; clears the set, no store clearing pass.
// ---------------------------------------------------------------------------
// closest_pair_brute_force - exhaustive closest pair of 2-D points
// Loads points up to capacity, finds the first pair with the smallest
// exact squared distance and returns its two points.
// ---------------------------------------------------------------------------
module closest_pair_brute_force import cpbf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpbf_point_if.sink    i_point,
    cpbf_result_if.source o_result
);

    t_cmd    cmd;
    t_status st;

    cpbf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_point.valid),
        .i_last_point (i_point.last_point),
        .o_in_ready   (i_point.ready),
        .o_out_valid  (o_result.valid),
        .i_out_ready  (o_result.ready),
        .i_status     (st),
        .o_cmd        (cmd)
    );

    cpbf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_point_x   (i_point.point_x),
        .i_point_y   (i_point.point_y),
        .o_status    (st),
        .o_result_x  (o_result.result_x),
        .o_result_y  (o_result.result_y),
        .o_truncated (o_result.truncated)
    );

    assign o_result.last_of_pair = cmd.out_second;

`ifndef ASSERT_OFF
    // no point is taken while a result is pending
    a_no_load_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !i_point.ready)
        else $error("point accepted while result pending");

    // the first point of the pair is always followed by the second
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.ready && !o_result.last_of_pair)
        |=> (o_result.valid && o_result.last_of_pair))
        else $error("second result missing");

    // held point count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.point_count <= t_cnt'(MAX_POINTS))
        else $error("point count beyond capacity");

    // result is never offered while distances are still in flight
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !st.pipe_busy)
        else $error("result offered before pipe drained");
`endif

endmodule
